FILE: rtl/core/crc_checked_frame_receiver_defines.svh
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// concurrent check on clk_i, quiet while in reset
`define CCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define CCFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ccfr_pkg.sv
package ccfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned BUF_AW      = $clog2(MAX_PAYLOAD);
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IDX_W       = 6;

  localparam logic [7:0]  SYNC_FIRST    = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND   = 8'h5A;
  localparam logic [7:0]  WANT_VERSION  = 8'h01;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [23:0] TIMEOUT_RESET = 24'd12500000;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VERSION = 2'd1,
    ST_BAD_LENGTH  = 2'd2,
    ST_BAD_CRC     = 2'd3
  } status_e;

  typedef struct packed {
    logic    idle_clr;
    logic    idle_inc;
    logic    crc_init;
    logic    crc_feed;
    logic    ld_version;
    logic    ld_command;
    logic    ld_sequence;
    logic    ld_len_lo;
    logic    ld_len_hi;
    logic    ld_crc_lo;
    logic    taken_clr;
    logic    store_wr;
    logic    emit_clr;
    logic    emit_rd;
    logic    emit_put;
    logic    res_put;
    status_e res_status;
  } ccfr_cmd_t;

  typedef struct packed {
    logic is_magic0;
    logic is_magic1;
    logic timeout_hit;
    logic len_too_big;
    logic len_zero;
    logic held_len_zero;
    logic payload_done;
    logic crc_ok;
    logic version_ok;
    logic emit_last;
    logic out_free;
  } ccfr_sts_t;

  // msb-first crc16, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/ccfr_in_if.sv
interface ccfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

FILE: rtl/core/ccfr_out_if.sv
interface ccfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  command;
  logic [7:0]  sequence_res;
  logic [15:0] frame_length;
  logic        byte_valid;
  logic [5:0]  byte_index;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, status, command, sequence_res, frame_length, byte_valid,
                  byte_index, payload_byte, last, input ready);
  modport sink (input valid, status, command, sequence_res, frame_length, byte_valid,
                byte_index, payload_byte, last, output ready);
endinterface

FILE: rtl/core/ccfr_ctrl.sv
module ccfr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  action_i,
  output logic                  in_ready_o,
  input  ccfr_pkg::ccfr_sts_t   sts_i,
  output ccfr_pkg::ccfr_cmd_t   cmd_o
);
  import ccfr_pkg::*;

  typedef enum logic [11:0] {
    S_HUNT     = 12'b0000_0000_0001,
    S_MAGIC1   = 12'b0000_0000_0010,
    S_VERSION  = 12'b0000_0000_0100,
    S_COMMAND  = 12'b0000_0000_1000,
    S_SEQUENCE = 12'b0000_0001_0000,
    S_LEN_LO   = 12'b0000_0010_0000,
    S_LEN_HI   = 12'b0000_0100_0000,
    S_PAYLOAD  = 12'b0000_1000_0000,
    S_CRC_LO   = 12'b0001_0000_0000,
    S_CRC_HI   = 12'b0010_0000_0000,
    S_EMIT_RD  = 12'b0100_0000_0000,
    S_EMIT_PUT = 12'b1000_0000_0000
  } state_e;

  state_e    state_q, state_d;
  ccfr_cmd_t cmd;
  logic      emitting;
  logic      accept;
  logic      byte_fire;

  assign emitting   = (state_q == S_EMIT_RD) || (state_q == S_EMIT_PUT);
  assign in_ready_o = !emitting && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign byte_fire  = accept && !action_i;
  assign cmd_o      = cmd;

  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    state_d        = state_q;

    if (byte_fire) begin
      cmd.idle_clr = 1'b1;
    end

    unique case (state_q)
      S_HUNT: begin
        if (byte_fire && sts_i.is_magic0) begin
          state_d = S_MAGIC1;
        end
      end
      S_MAGIC1: begin
        if (byte_fire) begin
          if (sts_i.is_magic1) begin
            cmd.crc_init = 1'b1;
            state_d      = S_VERSION;
          end else begin
            cmd.res_put    = 1'b1;
            cmd.res_status = ST_BAD_CRC;
            state_d        = S_HUNT;
          end
        end
      end
      S_VERSION: begin
        if (byte_fire) begin
          cmd.ld_version = 1'b1;
          cmd.crc_feed   = 1'b1;
          state_d        = S_COMMAND;
        end
      end
      S_COMMAND: begin
        if (byte_fire) begin
          cmd.ld_command = 1'b1;
          cmd.crc_feed   = 1'b1;
          state_d        = S_SEQUENCE;
        end
      end
      S_SEQUENCE: begin
        if (byte_fire) begin
          cmd.ld_sequence = 1'b1;
          cmd.crc_feed    = 1'b1;
          state_d         = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (byte_fire) begin
          cmd.ld_len_lo = 1'b1;
          cmd.crc_feed  = 1'b1;
          state_d       = S_LEN_HI;
        end
      end
      S_LEN_HI: begin
        if (byte_fire) begin
          cmd.ld_len_hi = 1'b1;
          cmd.crc_feed  = 1'b1;
          if (sts_i.len_too_big) begin
            cmd.res_put    = 1'b1;
            cmd.res_status = ST_BAD_LENGTH;
            state_d        = S_HUNT;
          end else begin
            cmd.taken_clr = 1'b1;
            state_d       = sts_i.len_zero ? S_CRC_LO : S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        if (byte_fire) begin
          cmd.store_wr = 1'b1;
          cmd.crc_feed = 1'b1;
          if (sts_i.payload_done) begin
            state_d = S_CRC_LO;
          end
        end
      end
      S_CRC_LO: begin
        if (byte_fire) begin
          cmd.ld_crc_lo = 1'b1;
          state_d       = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (byte_fire) begin
          state_d = S_HUNT;
          if (!sts_i.crc_ok) begin
            cmd.res_put    = 1'b1;
            cmd.res_status = ST_BAD_CRC;
          end else if (!sts_i.version_ok) begin
            cmd.res_put    = 1'b1;
            cmd.res_status = ST_BAD_VERSION;
          end else if (sts_i.held_len_zero) begin
            cmd.res_put    = 1'b1;
            cmd.res_status = ST_OK;
          end else begin
            cmd.emit_clr = 1'b1;
            state_d      = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_d     = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (sts_i.out_free) begin
          cmd.emit_put = 1'b1;
          state_d      = sts_i.emit_last ? S_HUNT : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_HUNT;
      end
    endcase

    // silence counting while a frame is open
    if (accept && action_i && (state_q != S_HUNT)) begin
      cmd.idle_inc = 1'b1;
      if (sts_i.timeout_hit) begin
        cmd.idle_clr   = 1'b1;
        cmd.res_put    = 1'b1;
        cmd.res_status = ST_BAD_CRC;
        state_d        = S_HUNT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/ccfr_dpath.sv
module ccfr_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic [7:0]          rx_byte_i,
  input  ccfr_pkg::ccfr_cmd_t cmd_i,
  output ccfr_pkg::ccfr_sts_t sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          status_o,
  output logic [7:0]          command_o,
  output logic [7:0]          sequence_res_o,
  output logic [15:0]         frame_length_o,
  output logic                byte_valid_o,
  output logic [5:0]          byte_index_o,
  output logic [7:0]          payload_byte_o,
  output logic                last_o
);
  import ccfr_pkg::*;

  logic [23:0]      timeout_q;
  logic [23:0]      idle_q;
  logic [23:0]      idle_inc;
  logic [15:0]      crc_q;
  logic [7:0]       version_q;
  logic [7:0]       command_q, command_d;
  logic [7:0]       sequence_q, sequence_d;
  logic [15:0]      length_q, length_d;
  logic [15:0]      len_full;
  logic [CNT_W-1:0] taken_q;
  logic [7:0]       crc_lo_q;
  logic [CNT_W-1:0] emit_idx_q;
  logic [7:0]       store [MAX_PAYLOAD];
  logic [7:0]       rd_data_q;

  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [7:0]       out_command_q;
  logic [7:0]       out_sequence_q;
  logic [15:0]      out_length_q;
  logic             byte_valid_q;
  logic [IDX_W-1:0] byte_index_q;
  logic [7:0]       payload_byte_q;
  logic             last_q;

  assign idle_inc = idle_q + 24'd1;
  assign len_full = {rx_byte_i, length_q[7:0]};

  always_comb begin
    command_d  = cmd_i.ld_command ? rx_byte_i : command_q;
    sequence_d = cmd_i.ld_sequence ? rx_byte_i : sequence_q;
    length_d   = length_q;
    if (cmd_i.ld_len_lo) begin
      length_d = {8'h00, rx_byte_i};
    end else if (cmd_i.ld_len_hi) begin
      length_d = len_full;
    end
  end

  always_comb begin
    sts_o.is_magic0     = (rx_byte_i == SYNC_FIRST);
    sts_o.is_magic1     = (rx_byte_i == SYNC_SECOND);
    sts_o.timeout_hit   = (idle_inc >= timeout_q);
    sts_o.len_too_big   = (len_full > 16'(MAX_PAYLOAD));
    sts_o.len_zero      = (len_full == 16'd0);
    sts_o.held_len_zero = (length_q == 16'd0);
    sts_o.payload_done  = ((16'(taken_q) + 16'd1) >= length_q);
    sts_o.crc_ok        = ({rx_byte_i, crc_lo_q} == crc_q);
    sts_o.version_ok    = (version_q == WANT_VERSION);
    sts_o.emit_last     = ((16'(emit_idx_q) + 16'd1) == length_q);
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TIMEOUT_RESET;
      idle_q     <= '0;
      crc_q      <= CRC_INIT;
      version_q  <= '0;
      command_q  <= '0;
      sequence_q <= '0;
      length_q   <= '0;
      taken_q    <= '0;
      crc_lo_q   <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.idle_clr) begin
        idle_q <= '0;
      end else if (cmd_i.idle_inc) begin
        idle_q <= idle_inc;
      end
      if (cmd_i.crc_init) begin
        crc_q <= CRC_INIT;
      end else if (cmd_i.crc_feed) begin
        crc_q <= crc_feed(crc_q, rx_byte_i);
      end
      if (cmd_i.ld_version) begin
        version_q <= rx_byte_i;
      end
      command_q  <= command_d;
      sequence_q <= sequence_d;
      length_q   <= length_d;
      if (cmd_i.taken_clr) begin
        taken_q <= '0;
      end else if (cmd_i.store_wr) begin
        taken_q <= taken_q + CNT_W'(1);
      end
      if (cmd_i.ld_crc_lo) begin
        crc_lo_q <= rx_byte_i;
      end
      if (cmd_i.emit_clr) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_put) begin
        emit_idx_q <= emit_idx_q + CNT_W'(1);
      end
    end
  end

  // payload buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store[taken_q[BUF_AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.emit_rd) begin
      rd_data_q <= store[emit_idx_q[BUF_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_put || cmd_i.emit_put) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_put) begin
      status_q       <= cmd_i.res_status;
      out_command_q  <= command_d;
      out_sequence_q <= sequence_d;
      out_length_q   <= length_d;
      byte_valid_q   <= 1'b0;
      byte_index_q   <= '0;
      payload_byte_q <= '0;
      last_q         <= 1'b1;
    end else if (cmd_i.emit_put) begin
      status_q       <= ST_OK;
      out_command_q  <= command_q;
      out_sequence_q <= sequence_q;
      out_length_q   <= length_q;
      byte_valid_q   <= 1'b1;
      byte_index_q   <= IDX_W'(emit_idx_q);
      payload_byte_q <= rd_data_q;
      last_q         <= sts_o.emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign command_o      = out_command_q;
  assign sequence_res_o = out_sequence_q;
  assign frame_length_o = out_length_q;
  assign byte_valid_o   = byte_valid_q;
  assign byte_index_o   = byte_index_q;
  assign payload_byte_o = payload_byte_q;
  assign last_o         = last_q;

endmodule

FILE: rtl/core/crc_checked_frame_receiver.sv
// Frame receiver for a byte stream with CRC16 (poly 0x1021, init 0xFFFF) checking. Each input
// transaction is either one received byte or one timer tick; a byte or tick is taken every
// clock while the result register is free or being emptied and no payload is being read
// out. Failed frames give one status result; a good frame of N payload bytes gives N results
// (or one empty result when N is 0) and holds input ready low while the payload buffer is
// read out, one registered read and one result load per byte. The user must write the timeout
// register through cfg_we_i/cfg_wdata_i only while the block is idle; it does not enforce this.
module crc_checked_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  ccfr_in_if.sink     in_i,
  ccfr_out_if.source  out_o
);
  import ccfr_pkg::*;

  ccfr_cmd_t cmd;
  ccfr_sts_t sts;

  ccfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccfr_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_byte_i      (in_i.rx_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_o       (out_o.status),
    .command_o      (out_o.command),
    .sequence_res_o (out_o.sequence_res),
    .frame_length_o (out_o.frame_length),
    .byte_valid_o   (out_o.byte_valid),
    .byte_index_o   (out_o.byte_index),
    .payload_byte_o (out_o.payload_byte),
    .last_o         (out_o.last)
  );

endmodule

FILE: rtl/core/ccfr_checker.sv
`include "crc_checked_frame_receiver_defines.svh"

module ccfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic       byte_valid_i,
  input logic [5:0] byte_index_i,
  input logic [7:0] payload_byte_i,
  input logic       last_i
);
  import ccfr_pkg::*;

  // a stalled result holds
  `CCFR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(byte_valid_i) && $stable(byte_index_i) && $stable(payload_byte_i) && $stable(last_i), "stalled result changed")

  // error reports are single results
  `CCFR_ASSERT_IMP(a_err_single, out_valid_i && (status_i != ST_OK), !byte_valid_i && last_i, "error result not single")

  // an empty result closes its run
  `CCFR_ASSERT_IMP(a_empty_last, out_valid_i && !byte_valid_i, last_i, "empty result without last")

  // no input taken in the middle of a payload run
  `CCFR_ASSERT_IMP(a_run_blocks, out_valid_i && byte_valid_i && !last_i, !in_ready_i, "input ready during payload run")

endmodule

bind crc_checked_frame_receiver ccfr_checker u_ccfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .byte_valid_i   (out_o.byte_valid),
  .byte_index_i   (out_o.byte_index),
  .payload_byte_i (out_o.payload_byte),
  .last_i         (out_o.last)
);
